### design/isq_pkg.sv
// shared types and codes of the intake and shooter sequencer
package isq_pkg;

  // request codes carried by an input item
  typedef enum logic [2:0] {
    REQ_TICK         = 3'd0,
    REQ_INTAKE       = 3'd1,
    REQ_STOP_INTAKE  = 3'd2,
    REQ_EXHAUST      = 3'd3,
    REQ_PRIME        = 3'd4,
    REQ_STOP_SHOOTER = 3'd5,
    REQ_SHOOT        = 3'd6
  } req_type_e;

  // intake sequencer states
  typedef enum logic [2:0] {
    IN_IDLE    = 3'd0,
    IN_DETECT  = 3'd1,
    IN_HOLD    = 3'd2,
    IN_SHOOT   = 3'd3,
    IN_EXHAUST = 3'd4
  } intake_phase_e;

  // shooter sequencer states
  typedef enum logic [1:0] {
    SH_IDLE    = 2'd0,
    SH_SPINUP  = 2'd1,
    SH_READY   = 2'd2,
    SH_EXHAUST = 2'd3
  } shooter_phase_e;

  // shooter drive modes
  typedef enum logic [1:0] {
    SHM_ZERO     = 2'd0,
    SHM_VELOCITY = 2'd1,
    SHM_TORQUE   = 2'd2
  } shooter_mode_e;

  // intake drive modes
  localparam logic INM_TORQUE   = 1'b0;
  localparam logic INM_POSITION = 1'b1;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_INTAKE_CURRENTS   = 3'd0,
    CFG_INTAKE_DUTY       = 3'd1,
    CFG_MOVE_DISTANCE     = 3'd2,
    CFG_SPEED_TOLERANCE   = 3'd3,
    CFG_SPINUP_TIMEOUT    = 3'd4,
    CFG_SH_EXHAUST_CURR   = 3'd5,
    CFG_SH_EXHAUST_DUTY   = 3'd6
  } cfg_index_e;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;

  localparam logic [16:0] SpeedToleranceRst = 17'd62259;
  localparam logic [31:0] SpinupTimeoutRst  = 32'd1000;

  // one input item
  typedef struct packed {
    logic [2:0]         req_type;
    logic [31:0]        now_time;
    logic               magnet_healthy;
    logic signed [31:0] intake_position;
    logic signed [23:0] wheel_one_speed;
    logic signed [23:0] wheel_two_speed;
    logic [22:0]        target_speed;
  } isq_req_t;

  // one result item
  typedef struct packed {
    logic               intake_mode;
    logic signed [15:0] intake_current;
    logic [15:0]        intake_duty;
    logic signed [31:0] intake_goal;
    logic [1:0]         shooter_mode;
    logic [22:0]        shooter_speed_cmd;
    logic signed [15:0] shooter_current;
    logic [15:0]        shooter_duty;
    logic [2:0]         intake_phase;
    logic [1:0]         shooter_phase;
    logic               drive_valid;
  } isq_rsp_t;

endpackage

### design/isq_req_if.sv
// input item channel of the sequencer
interface isq_req_if;
  import isq_pkg::*;

  logic     valid;
  logic     ready;
  isq_req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/isq_rsp_if.sv
// result item channel of the sequencer
interface isq_rsp_if;
  import isq_pkg::*;

  logic     valid;
  logic     ready;
  isq_rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### design/intake_shooter_sequencer_core.sv
// intake and shooter sequencer: top level with config registers and item pipeline
// an accepted item passes through the input register and then the result register
// throughput: one item per cycle while the sink does not hold off; the state updates in stage two
// the result register and input register stall together only when the sink holds off
// reset: asynchronous active low; both sequencers go idle, goal, target and start
// time clear, registers take their documented reset values
module intake_shooter_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  isq_req_if.sink                       req_i,
  isq_rsp_if.source                     rsp_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [isq_pkg::CfgAddrW-1:0]  paddr,
  input  logic [isq_pkg::CfgDataW-1:0]  pwdata,
  output logic [isq_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);
  import isq_pkg::*;

  // configuration registers
  logic [47:0]        intake_currents_q;
  logic [47:0]        intake_duty_q;
  logic signed [31:0] move_distance_q;
  logic [16:0]        speed_tolerance_q;
  logic [31:0]        spinup_timeout_q;
  logic signed [15:0] sh_exhaust_curr_q;
  logic [15:0]        sh_exhaust_duty_q;

  logic       cfg_we;
  cfg_index_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cfg_index_e'(paddr[CfgAddrW-1:3]);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intake_currents_q <= '0;
      intake_duty_q     <= '0;
      move_distance_q   <= '0;
      speed_tolerance_q <= SpeedToleranceRst;
      spinup_timeout_q  <= SpinupTimeoutRst;
      sh_exhaust_curr_q <= '0;
      sh_exhaust_duty_q <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_INTAKE_CURRENTS: intake_currents_q <= pwdata[47:0];
        CFG_INTAKE_DUTY:     intake_duty_q     <= pwdata[47:0];
        CFG_MOVE_DISTANCE:   move_distance_q   <= pwdata[31:0];
        CFG_SPEED_TOLERANCE: speed_tolerance_q <= pwdata[16:0];
        CFG_SPINUP_TIMEOUT:  spinup_timeout_q  <= pwdata[31:0];
        CFG_SH_EXHAUST_CURR: sh_exhaust_curr_q <= pwdata[15:0];
        CFG_SH_EXHAUST_DUTY: sh_exhaust_duty_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      CFG_INTAKE_CURRENTS: prdata = {16'd0, intake_currents_q};
      CFG_INTAKE_DUTY:     prdata = {16'd0, intake_duty_q};
      CFG_MOVE_DISTANCE:   prdata = {32'd0, move_distance_q};
      CFG_SPEED_TOLERANCE: prdata = {47'd0, speed_tolerance_q};
      CFG_SPINUP_TIMEOUT:  prdata = {32'd0, spinup_timeout_q};
      CFG_SH_EXHAUST_CURR: prdata = {48'd0, sh_exhaust_curr_q};
      CFG_SH_EXHAUST_DUTY: prdata = {48'd0, sh_exhaust_duty_q};
      default:             prdata = '0;
    endcase
  end

  // pipeline handshake
  logic     in_valid_q;
  isq_req_t in_q;
  logic     out_valid_q;
  isq_rsp_t out_q;
  logic     advance;

  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign rsp_o.valid = out_valid_q;
  assign rsp_o.payload = out_q;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      in_q <= req_i.payload;
    end
  end

  // sequencer state
  intake_phase_e      intake_phase_q, intake_phase_d;
  shooter_phase_e     shooter_phase_q, shooter_phase_d;
  logic signed [31:0] goal_q, goal_d;
  logic [22:0]        speed_target_q, speed_target_d;
  logic [31:0]        spin_start_q, spin_start_d;
  logic               spin_started_q, spin_started_d;

  // exact speed compare: (w1 + w2) * 65536 against 2 * target * tolerance
  logic signed [24:0] wheel_sum;
  logic [39:0]        tgt_prod;
  logic signed [42:0] speed_diff;
  logic               speed_above;
  logic               speed_below;

  assign wheel_sum   = 25'(in_q.wheel_one_speed) + 25'(in_q.wheel_two_speed);
  assign tgt_prod    = 40'(speed_target_q) * 40'(speed_tolerance_q);
  assign speed_diff  = {{2{wheel_sum[24]}}, wheel_sum, 16'd0} - {2'b0, tgt_prod, 1'b0};
  assign speed_above = !speed_diff[42] && (speed_diff != '0);
  assign speed_below = speed_diff[42];

  // spin-up timing
  logic [31:0] start_eff;
  logic [31:0] elapsed;

  assign start_eff = spin_started_q ? spin_start_q : in_q.now_time;
  assign elapsed   = in_q.now_time - start_eff;

  // next state
  always_comb begin
    intake_phase_d  = intake_phase_q;
    shooter_phase_d = shooter_phase_q;
    goal_d          = goal_q;
    speed_target_d  = speed_target_q;
    spin_start_d    = spin_start_q;
    spin_started_d  = spin_started_q;
    case (req_type_e'(in_q.req_type))
      REQ_TICK: begin
        if (intake_phase_q == IN_DETECT && !in_q.magnet_healthy) begin
          intake_phase_d = IN_HOLD;
          goal_d         = in_q.intake_position + move_distance_q;
        end
        case (shooter_phase_q)
          SH_SPINUP: begin
            spin_start_d   = start_eff;
            spin_started_d = 1'b1;
            if (speed_above || (elapsed > spinup_timeout_q)) begin
              shooter_phase_d = SH_READY;
            end
          end
          SH_READY: begin
            if (speed_below) begin
              shooter_phase_d = SH_SPINUP;
            end
          end
          default: ;
        endcase
      end
      REQ_INTAKE: begin
        if (intake_phase_q != IN_DETECT && intake_phase_q != IN_HOLD &&
            intake_phase_q != IN_SHOOT) begin
          intake_phase_d = IN_DETECT;
        end
      end
      REQ_STOP_INTAKE: begin
        if (intake_phase_q != IN_HOLD) begin
          intake_phase_d = IN_IDLE;
        end
      end
      REQ_EXHAUST: begin
        intake_phase_d  = IN_EXHAUST;
        shooter_phase_d = SH_EXHAUST;
      end
      REQ_PRIME: begin
        speed_target_d = in_q.target_speed;
        if (shooter_phase_q != SH_SPINUP && shooter_phase_q != SH_READY) begin
          shooter_phase_d = SH_SPINUP;
          spin_started_d  = 1'b0;
          spin_start_d    = '0;
        end
      end
      REQ_STOP_SHOOTER: shooter_phase_d = SH_IDLE;
      REQ_SHOOT: begin
        if (shooter_phase_q == SH_READY) begin
          intake_phase_d = IN_SHOOT;
        end
      end
      default: ;
    endcase
  end

  // result item: drive fields from the state before the item, phases after it
  isq_rsp_t rsp_d;

  always_comb begin
    rsp_d               = '0;
    rsp_d.intake_phase  = intake_phase_d;
    rsp_d.shooter_phase = shooter_phase_d;
    if (req_type_e'(in_q.req_type) == REQ_TICK) begin
      rsp_d.drive_valid = 1'b1;
      case (intake_phase_q)
        IN_DETECT: begin
          rsp_d.intake_mode    = INM_TORQUE;
          rsp_d.intake_current = intake_currents_q[15:0];
          rsp_d.intake_duty    = intake_duty_q[15:0];
        end
        IN_HOLD: begin
          rsp_d.intake_mode = INM_POSITION;
          rsp_d.intake_goal = goal_q;
        end
        IN_SHOOT: begin
          rsp_d.intake_mode    = INM_TORQUE;
          rsp_d.intake_current = intake_currents_q[31:16];
          rsp_d.intake_duty    = intake_duty_q[31:16];
        end
        IN_EXHAUST: begin
          rsp_d.intake_mode    = INM_TORQUE;
          rsp_d.intake_current = intake_currents_q[47:32];
          rsp_d.intake_duty    = intake_duty_q[47:32];
        end
        default: ;
      endcase
      case (shooter_phase_q)
        SH_SPINUP, SH_READY: begin
          rsp_d.shooter_mode      = SHM_VELOCITY;
          rsp_d.shooter_speed_cmd = speed_target_q;
        end
        SH_EXHAUST: begin
          rsp_d.shooter_mode    = SHM_TORQUE;
          rsp_d.shooter_current = sh_exhaust_curr_q;
          rsp_d.shooter_duty    = sh_exhaust_duty_q;
        end
        default: rsp_d.shooter_mode = SHM_ZERO;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      intake_phase_q  <= IN_IDLE;
      shooter_phase_q <= SH_IDLE;
      goal_q          <= '0;
      speed_target_q  <= '0;
      spin_start_q    <= '0;
      spin_started_q  <= 1'b0;
    end else if (advance) begin
      intake_phase_q  <= intake_phase_d;
      shooter_phase_q <= shooter_phase_d;
      goal_q          <= goal_d;
      speed_target_q  <= speed_target_d;
      spin_start_q    <= spin_start_d;
      spin_started_q  <= spin_started_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= rsp_d;
    end
  end

endmodule
